[rtl/core/icr_pkg.sv]
// ----------------------------------------------------------------------------
// icr_pkg - shared constants for the integer cube root block
// Default operand width and the fixed width of the returned root.
// ----------------------------------------------------------------------------
package icr_pkg;

  // default operand width handed to the top level
  localparam int WIDTH_DEF = 32;

  // width of the signed root on the result channel
  localparam int ROOT_BITS = 12;

endpackage : icr_pkg

[rtl/core/integer_cube_root.sv]
// ----------------------------------------------------------------------------
// integer_cube_root - pipelined floor cube root
// Returns the cube root of a WIDTH-bit operand, unsigned or two's complement
// (truncated toward zero), one digit of the root per pipeline stage.
//
//   channel  | signals                           | dir | payload
//   ---------+-----------------------------------+-----+---------------------
//   in       | in_valid, in_ready, in_operand    | in  | WIDTH-bit operand
//   out      | out_valid, out_ready, out_root    | out | 12-bit signed root
//   cfg      | cfg_valid, cfg_ready,             | in  | signed mode bit
//            | cfg_signed_mode                   |     |
//
// One request enters per cycle while no result is waiting at the output. The
// pipe holds an input stage that takes the magnitude, one stage per root
// digit, and the output register that puts the sign back.
// A result waiting at the output freezes every stage at once; no request is
// lost or repeated. Reset clears the valid bits and the signed mode.
// ----------------------------------------------------------------------------
module integer_cube_root #(
  parameter int WIDTH = icr_pkg::WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [WIDTH-1:0]                   in_operand,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [icr_pkg::ROOT_BITS-1:0] out_root,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_signed_mode
);

  localparam int RW    = (WIDTH - 1) / 3 + 1;
  localparam int SW    = 2 * RW;
  localparam int NSTEP = RW;
  localparam int EW    = (RW > icr_pkg::ROOT_BITS) ? RW : icr_pkg::ROOT_BITS;

  logic             signed_mode_r;
  logic             en;
  logic             neg_in;
  logic             min_in;
  logic [WIDTH-1:0] mag_in;
  logic             vld0_r;
  logic             neg0_r;
  logic [WIDTH-1:0] x0_r;

  logic             vld [0:NSTEP];
  logic             neg [0:NSTEP];
  logic [WIDTH-1:0] xr  [0:NSTEP];
  logic [RW-1:0]    yr  [0:NSTEP];
  logic [SW-1:0]    sq  [0:NSTEP-1];

  logic [EW-1:0]    y_ext;
  logic [EW-1:0]    root_nxt;
  logic             out_valid_r;
  logic [icr_pkg::ROOT_BITS-1:0] out_root_r;

  // configuration register, user must write it only while idle; unenforced
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      signed_mode_r <= cfg_signed_mode;
    end
  end

  // advance the whole pipe unless a result is waiting
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // take the magnitude; the most negative value yields zero
  assign neg_in = signed_mode_r && in_operand[WIDTH-1];
  assign min_in = neg_in && (in_operand[WIDTH-2:0] == '0);

  always_comb begin
    if (min_in) begin
      mag_in = '0;
    end else if (neg_in) begin
      mag_in = WIDTH'(~in_operand + WIDTH'(1));
    end else begin
      mag_in = in_operand;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= neg_in;
      x0_r   <= mag_in;
    end
  end

  assign vld[0] = vld0_r;
  assign neg[0] = neg0_r;
  assign xr[0]  = x0_r;
  assign yr[0]  = '0;
  assign sq[0]  = '0;

  // one stage per root digit, most significant first
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    if (k < NSTEP - 1) begin : g_mid
      icr_step #(
        .WIDTH (WIDTH),
        .SHIFT ((NSTEP - 1 - k) * 3)
      ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld_i (vld[k]),
        .neg_i (neg[k]),
        .x_i   (xr[k]),
        .y_i   (yr[k]),
        .sq_i  (sq[k]),
        .vld_o (vld[k+1]),
        .neg_o (neg[k+1]),
        .x_o   (xr[k+1]),
        .y_o   (yr[k+1]),
        .sq_o  (sq[k+1])
      );
    end else begin : g_last
      icr_step #(
        .WIDTH (WIDTH),
        .SHIFT (0)
      ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld_i (vld[k]),
        .neg_i (neg[k]),
        .x_i   (xr[k]),
        .y_i   (yr[k]),
        .sq_i  (sq[k]),
        .vld_o (vld[k+1]),
        .neg_o (neg[k+1]),
        .x_o   (xr[k+1]),
        .y_o   (yr[k+1]),
        .sq_o  ()
      );
    end
  end

  // restore the sign and truncate to the root field
  assign y_ext    = EW'(yr[NSTEP]);
  assign root_nxt = neg[NSTEP] ? EW'(~y_ext + EW'(1)) : y_ext;

  // output register; the final remainder is not needed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_root_r <= root_nxt[icr_pkg::ROOT_BITS-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

endmodule : integer_cube_root

[rtl/core/icr_step.sv]
// ----------------------------------------------------------------------------
// icr_step - one registered digit step of the cube root
// Doubles the partial root, tries 3y(y+1)+1 against the remainder shifted
// down by SHIFT and keeps the square of the root alongside it, so that the
// trial term needs only shifts and adds.
// ----------------------------------------------------------------------------
module icr_step #(
  parameter int WIDTH = icr_pkg::WIDTH_DEF,
  parameter int SHIFT = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            vld_i,
  input  logic                            neg_i,
  input  logic [WIDTH-1:0]                x_i,
  input  logic [(WIDTH-1)/3:0]            y_i,
  input  logic [2*((WIDTH-1)/3+1)-1:0]    sq_i,
  output logic                            vld_o,
  output logic                            neg_o,
  output logic [WIDTH-1:0]                x_o,
  output logic [(WIDTH-1)/3:0]            y_o,
  output logic [2*((WIDTH-1)/3+1)-1:0]    sq_o
);

  localparam int RW = (WIDTH - 1) / 3 + 1;
  localparam int SW = 2 * RW;
  localparam int CW = WIDTH + 4;

  logic [CW-1:0]    sq_ext;
  logic [CW-1:0]    y_ext;
  logic [CW-1:0]    trial;
  logic [CW-1:0]    x_shr;
  logic             fit;
  logic [RW-1:0]    y2;
  logic             vld_r;
  logic             neg_r;
  logic [WIDTH-1:0] x_r,  x_nxt;
  logic [RW-1:0]    y_r,  y_nxt;
  logic [SW-1:0]    sq_r, sq_nxt;

  // form trial term 12*y^2 + 6*y + 1 for the doubled root
  assign sq_ext = CW'(sq_i);
  assign y_ext  = CW'(y_i);
  assign trial  = (sq_ext << 3) + (sq_ext << 2) + (y_ext << 2) + (y_ext << 1)
                  + CW'(1);

  // compare against the remainder at this digit position
  assign x_shr = CW'(x_i) >> SHIFT;
  assign fit   = (x_shr >= trial);
  assign y2    = RW'({y_i, 1'b0});

  // subtract on fit and advance root and its square
  always_comb begin
    if (fit) begin
      x_nxt  = x_i - WIDTH'(trial << SHIFT);
      y_nxt  = y2 | RW'(1);
      sq_nxt = SW'((sq_ext << 2) + (y_ext << 2) + CW'(1));
    end else begin
      x_nxt  = x_i;
      y_nxt  = y2;
      sq_nxt = SW'(sq_ext << 2);
    end
  end

  // valid bit of this stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= neg_i;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      sq_r  <= sq_nxt;
    end
  end

  assign vld_o = vld_r;
  assign neg_o = neg_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign sq_o  = sq_r;

endmodule : icr_step
